// ===== sv/ipv6fp_pkg.sv =====
`timescale 1ns / 1ps

package ipv6fp_pkg;

  localparam int unsigned MIN_MTU      = 1280;
  localparam int unsigned MAX_FRAGS    = 64;
  localparam int unsigned IP6_HDR      = 40;
  localparam int unsigned FRAG_EXT_HDR = 8;
  localparam int unsigned JUMBO_LIMIT  = 65535 + IP6_HDR;

  localparam int unsigned DVD_W     = 17;
  localparam int unsigned DVS_W     = 16;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned QHI_W     = DVD_W - $clog2(MAX_FRAGS);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FS_LIMIT  = 4'd0,
    CFG_PMTU_MODE = 4'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PMTU_WANT = 2'd0,
    PMTU_DONT = 2'd1,
    PMTU_DO   = 2'd2
  } pmtu_e;

  typedef enum logic [1:0] {
    KIND_WHOLE  = 2'd0,
    KIND_FRAG   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    kind_e        result_kind;
    logic [15:0]  fragment_offset;
    logic         more_fragments;
    logic [31:0]  identification;
    logic [15:0]  header_payload_length;
    logic [15:0]  chunk_offset;
    logic [15:0]  chunk_length;
    logic         jumbo;
    logic [15:0]  mtu_used;
    logic         last;
  } out_item_t;

endpackage

// ===== sv/ipv6fp_if.sv =====
`timescale 1ns / 1ps

interface ipv6fp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [7:0]  nonfrag_opt_len;
  logic [7:0]  frag_opt_len;
  logic [15:0] path_mtu;
  logic        raw_header;

  modport source (
    output valid, payload_length, nonfrag_opt_len, frag_opt_len, path_mtu, raw_header,
    input  ready
  );
  modport sink (
    input  valid, payload_length, nonfrag_opt_len, frag_opt_len, path_mtu, raw_header,
    output ready
  );
endinterface

interface ipv6fp_out_if;
  logic                  valid;
  logic                  ready;
  ipv6fp_pkg::kind_e     result_kind;
  logic [15:0]           fragment_offset;
  logic                  more_fragments;
  logic [31:0]           identification;
  logic [15:0]           header_payload_length;
  logic [15:0]           chunk_offset;
  logic [15:0]           chunk_length;
  logic                  jumbo;
  logic [15:0]           mtu_used;
  logic                  last;

  modport source (
    output valid, result_kind, fragment_offset, more_fragments, identification,
           header_payload_length, chunk_offset, chunk_length, jumbo, mtu_used, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, fragment_offset, more_fragments, identification,
           header_payload_length, chunk_offset, chunk_length, jumbo, mtu_used, last,
    output ready
  );
endinterface

interface ipv6fp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ipv6fp_pkg::CFG_IDX_W-1:0]  index;
  logic [ipv6fp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ipv6fp_div.sv =====
`timescale 1ns / 1ps

module ipv6fp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipv6fp_pkg::div_req_t req_i,
  output ipv6fp_pkg::div_rsp_t rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [ipv6fp_pkg::CNT_W-1:0]       cnt_q;
  logic [ipv6fp_pkg::DVD_W-1:0]       quo_q, quo_d;
  logic [ipv6fp_pkg::DVS_W-1:0]       rem_q, rem_d;
  logic [ipv6fp_pkg::DVS_W-1:0]       dvs_q;
  logic [ipv6fp_pkg::DVS_W:0]         rem_sh;
  logic                               ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[ipv6fp_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? ipv6fp_pkg::DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[ipv6fp_pkg::DVS_W-1:0];
    quo_d  = {quo_q[ipv6fp_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ipv6fp_pkg::CNT_W'(ipv6fp_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o = '{done: done_q, quot: quo_q, rem: rem_q};

endmodule

// ===== sv/ipv6_fragment_planner.sv =====
`timescale 1ns / 1ps

// IPv6 fragment planner.
// in_i takes one datagram descriptor per request; in_i.ready is high only
// while the block is idle. out_o returns one or more results per datagram,
// the final one marked by last. cfg_i is always ready; write it only while
// the block is idle (index 0 fragment size, index 1 discovery mode).
// A whole packet, or a rejection on jumbo, raw header or mode do, is
// set in ST_CALC; a rejection on the MTU check is set in ST_CHECK.
// Any other datagram runs a 17-step shift-subtract divider in ST_DIV and
// then shows its first fragment, or its rejection for too many fragments;
// the following fragments come one per cycle while out_o.ready stays high.
// The next request is taken in the cycle after the last result is accepted.
// When the receiver stalls, the pending result holds in the output register
// and the sequencer waits.
// Reset clears the configuration to zero and sets the identification
// counter to one; no result is pending after reset.

module ipv6_fragment_planner (
  input  logic               clk_i,
  input  logic               rst_ni,
  ipv6fp_cfg_if.sink         cfg_i,
  ipv6fp_in_if.sink          in_i,
  ipv6fp_out_if.source       out_o
);

  ipv6fp_pkg::st_e       st_q, st_d;
  logic [15:0]           fs_limit_q;
  logic [1:0]            pmtu_mode_q;
  logic [31:0]           ident_q, ident_d;

  logic [15:0]           len_q, len_d;
  logic [7:0]            nflen_q, nflen_d;
  logic [7:0]            flen_q, flen_d;
  logic [15:0]           pmtu_q, pmtu_d;
  logic                  raw_q, raw_d;
  logic [15:0]           mtu_q, mtu_d;
  logic [15:0]           flen8_q, flen8_d;
  logic [ipv6fp_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [16:0]           off_q, off_d;
  logic                  tot_zero_q, tot_zero_d;
  ipv6fp_pkg::out_item_t out_q, out_d;

  ipv6fp_pkg::div_req_t  div_req;
  ipv6fp_pkg::div_rsp_t  div_rsp;

  logic [15:0]           fs_sat;
  logic [15:0]           mtu_c;
  logic [16:0]           pkt_c;
  logic                  jumbo_c;
  logic [8:0]            unfrag_c;
  logic [16:0]           room_c;
  logic [15:0]           flen8_c;
  logic [16:0]           total_c;
  logic [16:0]           last_off_c;
  logic [15:0]           tail_len_c;
  logic [16:0]           nxt_off_c;

  function automatic ipv6fp_pkg::out_item_t make_reject(logic [15:0] mtu, logic jumbo);
    ipv6fp_pkg::out_item_t r;
    r             = '0;
    r.result_kind = ipv6fp_pkg::KIND_REJECT;
    r.jumbo       = jumbo;
    r.mtu_used    = mtu;
    r.last        = 1'b1;
    return r;
  endfunction

  ipv6fp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (st_q == ipv6fp_pkg::ST_IDLE);
  assign out_o.valid = (st_q == ipv6fp_pkg::ST_EMIT);

  assign out_o.result_kind           = out_q.result_kind;
  assign out_o.fragment_offset       = out_q.fragment_offset;
  assign out_o.more_fragments        = out_q.more_fragments;
  assign out_o.identification        = out_q.identification;
  assign out_o.header_payload_length = out_q.header_payload_length;
  assign out_o.chunk_offset          = out_q.chunk_offset;
  assign out_o.chunk_length          = out_q.chunk_length;
  assign out_o.jumbo                 = out_q.jumbo;
  assign out_o.mtu_used              = out_q.mtu_used;
  assign out_o.last                  = out_q.last;

  always_comb begin
    // effective MTU and packet size
    fs_sat = fs_limit_q;
    if (fs_limit_q != '0 && fs_limit_q < 16'(ipv6fp_pkg::MIN_MTU)) begin
      fs_sat = 16'(ipv6fp_pkg::MIN_MTU);
    end
    mtu_c = pmtu_q;
    if (fs_sat < pmtu_q) begin
      if (fs_sat != '0) begin
        mtu_c = fs_sat;
      end else if (pmtu_mode_q == ipv6fp_pkg::PMTU_DONT) begin
        mtu_c = 16'(ipv6fp_pkg::MIN_MTU);
      end
    end
    if (raw_q) begin
      pkt_c = {1'b0, len_q};
    end else begin
      pkt_c = {1'b0, len_q} + 17'(ipv6fp_pkg::IP6_HDR) + 17'(flen_q) + 17'(nflen_q);
    end
    jumbo_c = !raw_q && (pkt_c > 17'(ipv6fp_pkg::JUMBO_LIMIT));

    // fragmentable room per fragment
    unfrag_c = 9'(ipv6fp_pkg::IP6_HDR + ipv6fp_pkg::FRAG_EXT_HDR) + 9'(nflen_q);
    room_c   = {1'b0, mtu_q} - 17'(unfrag_c);
    flen8_c  = {room_c[15:3], 3'b000};
    total_c  = {1'b0, len_q} + 17'(flen_q);

    // last fragment from quotient and remainder
    last_off_c = tot_zero_q ? '0 : (dvd_q - 17'(div_rsp.rem));
    tail_len_c = tot_zero_q ? '0 : (div_rsp.rem + 16'd1);
    nxt_off_c  = off_q - {1'b0, flen8_q};
  end

  always_comb begin
    st_d       = st_q;
    ident_d    = ident_q;
    len_d      = len_q;
    nflen_d    = nflen_q;
    flen_d     = flen_q;
    pmtu_d     = pmtu_q;
    raw_d      = raw_q;
    mtu_d      = mtu_q;
    flen8_d    = flen8_q;
    dvd_d      = dvd_q;
    off_d      = off_q;
    tot_zero_d = tot_zero_q;
    out_d      = out_q;
    div_req    = '0;

    case (st_q)
      ipv6fp_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          len_d   = in_i.payload_length;
          nflen_d = in_i.nonfrag_opt_len;
          flen_d  = in_i.frag_opt_len;
          pmtu_d  = in_i.path_mtu;
          raw_d   = in_i.raw_header;
          st_d    = ipv6fp_pkg::ST_CALC;
        end
      end

      ipv6fp_pkg::ST_CALC: begin
        mtu_d = mtu_c;
        if (!jumbo_c && pkt_c <= {1'b0, mtu_c}) begin
          out_d                       = '0;
          out_d.result_kind           = ipv6fp_pkg::KIND_WHOLE;
          out_d.header_payload_length = raw_q ? '0
                                      : 16'(pkt_c - 17'(ipv6fp_pkg::IP6_HDR));
          out_d.chunk_length          = len_q;
          out_d.mtu_used              = mtu_c;
          out_d.last                  = 1'b1;
          st_d                        = ipv6fp_pkg::ST_EMIT;
        end else if (raw_q || jumbo_c || pmtu_mode_q == ipv6fp_pkg::PMTU_DO) begin
          out_d = make_reject(mtu_c, jumbo_c);
          st_d  = ipv6fp_pkg::ST_EMIT;
        end else begin
          st_d = ipv6fp_pkg::ST_CHECK;
        end
      end

      ipv6fp_pkg::ST_CHECK: begin
        if (mtu_q <= 16'(unfrag_c) || flen8_c == '0 || flen8_c < 16'(flen_q)) begin
          out_d = make_reject(mtu_q, 1'b0);
          st_d  = ipv6fp_pkg::ST_EMIT;
        end else begin
          flen8_d          = flen8_c;
          tot_zero_d       = (total_c == '0);
          dvd_d            = (total_c == '0) ? '0 : (total_c - 17'd1);
          div_req.start    = 1'b1;
          div_req.dividend = (total_c == '0) ? '0 : (total_c - 17'd1);
          div_req.divisor  = flen8_c;
          st_d             = ipv6fp_pkg::ST_DIV;
        end
      end

      ipv6fp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          st_d = ipv6fp_pkg::ST_EMIT;
          if (div_rsp.quot[ipv6fp_pkg::DVD_W-1 -: ipv6fp_pkg::QHI_W] != '0) begin
            out_d = make_reject(mtu_q, 1'b0);
          end else begin
            ident_d = (ident_q == 32'hFFFF_FFFF) ? 32'd1 : (ident_q + 32'd1);
            off_d   = last_off_c;
            out_d                       = '0;
            out_d.result_kind           = ipv6fp_pkg::KIND_FRAG;
            out_d.identification        = ident_q;
            out_d.header_payload_length = 16'(ipv6fp_pkg::FRAG_EXT_HDR) + 16'(nflen_q)
                                        + tail_len_c;
            out_d.mtu_used              = mtu_q;
            if (div_rsp.quot == '0) begin
              out_d.chunk_length = tail_len_c - 16'(flen_q);
              out_d.last         = 1'b1;
            end else begin
              out_d.fragment_offset = last_off_c[15:0];
              out_d.chunk_offset    = 16'(last_off_c - 17'(flen_q));
              out_d.chunk_length    = tail_len_c;
            end
          end
        end
      end

      ipv6fp_pkg::ST_EMIT: begin
        if (out_o.ready) begin
          if (out_q.last) begin
            st_d = ipv6fp_pkg::ST_IDLE;
          end else begin
            off_d                       = nxt_off_c;
            out_d.fragment_offset       = nxt_off_c[15:0];
            out_d.more_fragments        = 1'b1;
            out_d.header_payload_length = 16'(ipv6fp_pkg::FRAG_EXT_HDR) + 16'(nflen_q)
                                        + flen8_q;
            if (nxt_off_c == '0) begin
              out_d.chunk_offset = '0;
              out_d.chunk_length = flen8_q - 16'(flen_q);
              out_d.last         = 1'b1;
            end else begin
              out_d.chunk_offset = 16'(nxt_off_c - 17'(flen_q));
              out_d.chunk_length = flen8_q;
              out_d.last         = 1'b0;
            end
          end
        end
      end

      default: begin
        st_d = ipv6fp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ipv6fp_pkg::ST_IDLE;
      fs_limit_q  <= '0;
      pmtu_mode_q <= '0;
      ident_q     <= 32'd1;
    end else begin
      st_q    <= st_d;
      ident_q <= ident_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == ipv6fp_pkg::CFG_FS_LIMIT) begin
          fs_limit_q <= cfg_i.data;
        end else if (cfg_i.index == ipv6fp_pkg::CFG_PMTU_MODE) begin
          pmtu_mode_q <= cfg_i.data[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    nflen_q    <= nflen_d;
    flen_q     <= flen_d;
    pmtu_q     <= pmtu_d;
    raw_q      <= raw_d;
    mtu_q      <= mtu_d;
    flen8_q    <= flen8_d;
    dvd_q      <= dvd_d;
    off_q      <= off_d;
    tot_zero_q <= tot_zero_d;
    out_q      <= out_d;
  end

endmodule

// ===== sv/ipv6fp_chk.sv =====
`timescale 1ns / 1ps

module ipv6fp_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in flight");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("ready for a request while a result is pending");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a fragment burst");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != ipv6fp_pkg::KIND_FRAG |-> out_last_i)
    else $error("whole or rejected result not marked last");

endmodule

bind ipv6_fragment_planner ipv6fp_chk u_ipv6fp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.result_kind),
  .out_last_i  (out_o.last)
);
